// ----- sv/mpc_pkg.sv -----
// Shared types and constants of the mDNS packet classifier.
`timescale 1ns / 1ps
package mpc_pkg;

    // Widest byte position the walk can reach (message, pointer or skipped data).
    localparam int POS_W = 18;
    localparam int REG_LABEL_BYTES = 24;
    localparam int ID_BYTES = 17;
    localparam int SRVC_LEN = 34;
    localparam int HAP_LEN = 16;
    localparam int HOST_SUFFIX_AT = 9;

    localparam logic [7:0] TAG_PTR = 8'hC0;
    localparam logic [7:0] TAG_MAX_LABEL = 8'h40;
    localparam logic [7:0] FLAGS_RESPONSE = 8'h84;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    localparam logic [15:0] TYPE_A = 16'd1;
    localparam logic [15:0] TYPE_PTR = 16'd12;
    localparam logic [15:0] TYPE_TXT = 16'd16;
    localparam logic [15:0] TYPE_AAAA = 16'd28;
    localparam logic [15:0] TYPE_SRV = 16'd33;
    localparam logic [15:0] TYPE_ANY = 16'd255;

    localparam int BIT_QM = 8;
    localparam int BIT_KA_TXT = 16;
    localparam int BIT_KA_SRV = 17;
    localparam int BIT_KA_A = 18;
    localparam int BIT_KA_PTR = 19;
    localparam int BIT_KA_AAAA = 20;
    localparam int BIT_AU_HOST = 21;
    localparam int BIT_AU_SRVC = 22;
    localparam int BIT_CF_TXT = 24;
    localparam int BIT_CF_SRV = 25;
    localparam int BIT_CF_A = 26;
    localparam int BIT_CF_AAAA = 28;
    localparam int BIT_CF_HOST = 29;
    localparam int BIT_CF_SRVC = 30;

    localparam logic [7:0] HAP_NAME [HAP_LEN] = '{
        8'h5F, 8'h68, 8'h61, 8'h70, 8'h2E, 8'h5F, 8'h74, 8'h63,
        8'h70, 8'h2E, 8'h6C, 8'h6F, 8'h63, 8'h61, 8'h6C, 8'h2E
    };

    typedef enum logic [2:0] {
        CFG_DEV_LOW,
        CFG_DEV_MID,
        CFG_DEV_LAST,
        CFG_HOST_A,
        CFG_HOST_B,
        CFG_HOST_C,
        CFG_HOST_LEN,
        CFG_OWN_IP
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] dev_low;
        logic [63:0] dev_mid;
        logic [7:0]  dev_last;
        logic [63:0] host_a;
        logic [63:0] host_b;
        logic [63:0] host_c;
        logic [4:0]  host_len;
        logic [31:0] own_ip;
    } t_cfg;

    typedef struct packed {
        logic [30:0] hit_map;
        logic        malformed;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_HDR,
        S_NEXT,
        S_NSTART,
        S_NTAG,
        S_NLAB,
        S_NDOT,
        S_NPTR,
        S_AFTER,
        S_QT0,
        S_QT1,
        S_QC,
        S_AT0,
        S_AT1,
        S_AA,
        S_SK0,
        S_SK1,
        S_DONE
    } t_pstate;

    typedef enum logic [1:0] {
        SEC_QUESTION,
        SEC_ANSWER,
        SEC_SKIP,
        SEC_AUTH
    } t_sec;

endpackage

// ----- sv/mpc_in_if.sv -----
// Input channel: one message byte per item.
`timescale 1ns / 1ps
interface mpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       probing_now;

    modport source(output valid, packet_byte, last_byte, probing_now, input ready);
    modport sink(input valid, packet_byte, last_byte, probing_now, output ready);
endinterface

// ----- sv/mpc_out_if.sv -----
// Output channel: one classification result per message.
`timescale 1ns / 1ps
interface mpc_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] hit_map;
    logic        malformed;

    modport source(output valid, hit_map, malformed, input ready);
    modport sink(input valid, hit_map, malformed, output ready);
endinterface

// ----- sv/mpc_ram.sv -----
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module mpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/mpc_loader.sv -----
// Front end: stores message bytes and queues a parse job on the last byte.
`timescale 1ns / 1ps
module mpc_loader
    import mpc_pkg::*;
#(
    parameter int PACKET_BYTES = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mpc_in_if.sink                          i_in,
    output logic                            o_we,
    output logic [$clog2(PACKET_BYTES)-1:0] o_waddr,
    output logic [7:0]                      o_wdata,
    output logic                            o_push,
    output logic [$clog2(PACKET_BYTES+1):0] o_job,
    input  logic                            i_q_full,
    input  logic                            i_done
);
    localparam int LW = $clog2(PACKET_BYTES + 1);
    localparam int AW = $clog2(PACKET_BYTES);

    logic [LW-1:0] r_count, n_count;
    logic          r_wait, n_wait;
    logic          w_accept;
    logic          w_room;
    logic [LW-1:0] w_count_inc;

    // The store is shared with the parser, so loading waits until the parse is over.
    assign i_in.ready = !r_wait && !i_q_full;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_room = r_count < LW'(PACKET_BYTES);
    assign w_count_inc = w_room ? r_count + LW'(1) : r_count;

    assign o_we = w_accept && w_room;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = i_in.packet_byte;
    assign o_push = w_accept && i_in.last_byte;
    assign o_job = {w_count_inc, i_in.probing_now};

    always_comb begin
        n_count = r_count;
        n_wait = r_wait;
        if (w_accept) begin
            n_count = i_in.last_byte ? '0 : w_count_inc;
            if (i_in.last_byte) begin
                n_wait = 1'b1;
            end
        end
        if (i_done) begin
            n_wait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wait <= 1'b0;
        end else begin
            r_count <= n_count;
            r_wait <= n_wait;
        end
    end
endmodule

// ----- sv/mpc_job_queue.sv -----
// Two-entry queue of parse jobs between the loader and the parser.
`timescale 1ns / 1ps
module mpc_job_queue #(
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output logic [DW-1:0] o_data
);
    logic [DW-1:0] r_data [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_full = r_cnt == 2'd2;
    assign o_data = r_data[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ----- sv/mpc_parser.sv -----
// Back end: walks the stored message, at most one byte read per cycle, and builds the hit map.
`timescale 1ns / 1ps
module mpc_parser
    import mpc_pkg::*;
#(
    parameter int PACKET_BYTES = 2048,
    parameter int NAME_LIMIT = 93,
    parameter int HOST_LABEL_BYTES = 24,
    parameter int POINTER_HOP_LIMIT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cfg                            i_cfg,
    input  logic                            i_job_valid,
    input  logic [$clog2(PACKET_BYTES+1):0] i_job,
    output logic                            o_job_pop,
    output logic [$clog2(PACKET_BYTES)-1:0] o_raddr,
    input  logic [7:0]                      i_rdata,
    output logic                            o_done,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output t_result                         o_res
);
    localparam int LW = $clog2(PACKET_BYTES + 1);
    localparam int AW = $clog2(PACKET_BYTES);
    localparam int NW = $clog2(NAME_LIMIT + 2);
    localparam int HW = $clog2(POINTER_HOP_LIMIT + 1);

    t_pstate          r_state, n_state;
    t_sec             r_sec, n_sec;
    logic             r_ptr, n_ptr;
    logic [LW-1:0]    r_len, n_len;
    logic             r_probe, n_probe;
    logic             r_resp, n_resp;
    logic             r_rej, n_rej;
    logic [3:0]       r_k, n_k;
    logic [7:0]       r_qu, n_qu;
    logic [15:0]      r_an, n_an;
    logic [15:0]      r_au, n_au;
    logic [POS_W-1:0] r_i, n_i;
    logic [POS_W-1:0] r_j, n_j;
    logic [NW-1:0]    r_n, n_n;
    logic [HW-1:0]    r_hops, n_hops;
    logic [6:0]       r_c, n_c;
    logic [7:0]       r_tag, n_tag;
    logic [7:0]       r_hi, n_hi;
    logic [7:0]       r_lo, n_lo;
    logic [23:0]      r_addr, n_addr;
    logic             r_ms, n_ms, r_mh, n_mh, r_mp, n_mp;
    logic             r_is_s, n_is_s, r_is_h, n_is_h, r_is_p, n_is_p;
    logic [30:0]      r_flags, n_flags;
    logic             r_mal, n_mal;
    logic             r_ov, n_ov;
    t_result          r_res, n_res;

    logic             w_rd_en;
    logic [POS_W-1:0] w_rd_pos;
    logic             w_rd_bad;
    logic [4:0]       w_lim;
    logic [5:0]       w_host_len;
    logic [7:0]       w_cmp;
    logic             w_s_ok, w_h_ok, w_p_ok;
    logic             w_tag_ptr, w_hop_over, w_lab_bad;
    logic             w_rej_now;
    logic [15:0]      w_typ;
    logic             w_out_free;
    logic [13:0]      w_ptr;

    // Target name bytes; the host label is clipped to the register and parameter limits.
    always_comb begin
        w_lim = (i_cfg.host_len > 5'(REG_LABEL_BYTES)) ? 5'(REG_LABEL_BYTES) : i_cfg.host_len;
        if (32'(w_lim) > HOST_LABEL_BYTES) begin
            w_lim = 5'(HOST_LABEL_BYTES);
        end
    end
    assign w_host_len = 6'(w_lim) + 6'd7;

    function automatic logic [7:0] srvc_byte(input logic [5:0] idx);
        logic [7:0] b;
        if (idx < 6'd8) begin
            b = i_cfg.dev_low[idx[2:0]*8 +: 8];
        end else if (idx < 6'd16) begin
            b = i_cfg.dev_mid[idx[2:0]*8 +: 8];
        end else if (idx == 6'(ID_BYTES - 1)) begin
            b = i_cfg.dev_last;
        end else if (idx == 6'(ID_BYTES)) begin
            b = CHAR_DOT;
        end else begin
            b = HAP_NAME[4'(idx - 6'(ID_BYTES + 1))];
        end
        return b;
    endfunction

    function automatic logic [7:0] host_byte(input logic [4:0] idx);
        logic [7:0] b;
        if (idx < w_lim) begin
            case (idx[4:3])
                2'd0:    b = i_cfg.host_a[idx[2:0]*8 +: 8];
                2'd1:    b = i_cfg.host_b[idx[2:0]*8 +: 8];
                default: b = i_cfg.host_c[idx[2:0]*8 +: 8];
            endcase
        end else begin
            b = HAP_NAME[4'(5'(HOST_SUFFIX_AT) + idx - w_lim)];
        end
        return b;
    endfunction

    assign w_cmp = (r_state == S_NDOT) ? CHAR_DOT : i_rdata;
    assign w_s_ok = (r_n < NW'(SRVC_LEN)) && (w_cmp == srvc_byte(r_n[5:0]));
    assign w_h_ok = (r_n < NW'(w_host_len)) && (w_cmp == host_byte(r_n[4:0]));
    assign w_p_ok = (r_n < NW'(HAP_LEN)) && (w_cmp == HAP_NAME[r_n[3:0]]);

    assign w_tag_ptr = i_rdata >= TAG_PTR;
    assign w_hop_over = r_hops >= HW'(POINTER_HOP_LIMIT);
    assign w_lab_bad = (i_rdata > TAG_MAX_LABEL)
        || ((r_j + POS_W'(1) + POS_W'(i_rdata)) > POS_W'(r_len))
        || ((10'(r_n) + 10'(i_rdata)) > 10'(NAME_LIMIT));
    assign w_ptr = {i_rdata[5:0] - r_tag[5:0] + r_tag[5:0], 8'h00} | 14'(0);

    always_comb begin
        w_rej_now = r_rej;
        case (r_k)
            4'd0, 4'd1, 4'd3, 4'd4: w_rej_now = r_rej || (i_rdata != 8'h00);
            4'd2: w_rej_now = r_rej || ((i_rdata != 8'h00) && (i_rdata != FLAGS_RESPONSE));
            default: w_rej_now = r_rej;
        endcase
    end

    assign w_typ = {r_hi, i_rdata};
    assign w_out_free = !r_ov || i_res_ready;
    assign w_rd_bad = w_rd_pos >= POS_W'(r_len);
    assign o_raddr = w_rd_pos[AW-1:0];
    assign o_res_valid = r_ov;
    assign o_res = r_res;

    // Datapath and read port.
    always_comb begin
        logic [6:0] qbit;
        n_sec = r_sec; n_ptr = r_ptr; n_len = r_len; n_probe = r_probe;
        n_resp = r_resp; n_rej = r_rej; n_k = r_k; n_qu = r_qu; n_an = r_an; n_au = r_au;
        n_i = r_i; n_j = r_j; n_n = r_n; n_hops = r_hops; n_c = r_c; n_tag = r_tag;
        n_hi = r_hi; n_lo = r_lo; n_addr = r_addr;
        n_ms = r_ms; n_mh = r_mh; n_mp = r_mp;
        n_is_s = r_is_s; n_is_h = r_is_h; n_is_p = r_is_p;
        n_flags = r_flags; n_mal = r_mal; n_res = r_res;
        n_ov = r_ov && !i_res_ready;
        w_rd_en = 1'b0;
        w_rd_pos = r_i;
        o_job_pop = 1'b0;
        o_done = 1'b0;
        qbit = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_len = i_job[LW:1];
                    n_probe = i_job[0];
                end
            end
            S_START: begin
                w_rd_en = 1'b1;
                w_rd_pos = '0;
                n_flags = '0;
                n_mal = 1'b0;
                n_rej = 1'b0;
                n_resp = 1'b0;
                n_k = '0;
            end
            S_HDR: begin
                n_k = r_k + 4'd1;
                if (r_k <= 4'd4) begin
                    n_rej = w_rej_now;
                end
                case (r_k)
                    4'd2: n_resp = i_rdata == FLAGS_RESPONSE;
                    4'd5: n_qu = i_rdata;
                    4'd6: n_an[15:8] = i_rdata;
                    4'd7: n_an[7:0] = i_rdata;
                    4'd8: n_au[15:8] = i_rdata;
                    4'd9: n_au[7:0] = i_rdata;
                    default: ;
                endcase
                w_rd_en = (r_k < 4'd9) && !((r_k == 4'd4) && w_rej_now);
                w_rd_pos = POS_W'(r_k) + POS_W'(1);
                if (r_k == 4'd9) begin
                    n_i = POS_W'(12);
                    n_sec = SEC_QUESTION;
                end
            end
            S_NEXT: begin
                n_ptr = 1'b0;
                case (r_sec)
                    SEC_QUESTION: begin
                        if (r_qu != 8'd0) begin
                            n_qu = r_qu - 8'd1;
                        end else begin
                            n_sec = ((r_flags != '0) || r_resp) ? SEC_ANSWER : SEC_SKIP;
                        end
                    end
                    SEC_ANSWER, SEC_SKIP: begin
                        if (r_an != 16'd0) begin
                            n_an = r_an - 16'd1;
                        end else begin
                            n_sec = SEC_AUTH;
                        end
                    end
                    default: begin
                        if (r_au != 16'd0) begin
                            n_au = r_au - 16'd1;
                        end
                    end
                endcase
            end
            S_NSTART: begin
                w_rd_en = 1'b1;
                w_rd_pos = r_i;
                n_j = r_i;
                n_n = '0;
                n_hops = '0;
                n_ms = 1'b1;
                n_mh = 1'b1;
                n_mp = 1'b1;
            end
            S_NTAG: begin
                n_tag = i_rdata;
                if (i_rdata == 8'h00) begin
                    if (r_hops == '0) begin
                        n_i = r_i + POS_W'(1);
                    end
                    n_is_s = r_ms && (r_n == NW'(SRVC_LEN));
                    n_is_h = r_mh && (r_n == NW'(w_host_len));
                    n_is_p = r_mp && (r_n == NW'(HAP_LEN));
                end else if (w_tag_ptr) begin
                    if (w_hop_over) begin
                        n_mal = 1'b1;
                    end else begin
                        n_hops = r_hops + HW'(1);
                        w_rd_en = 1'b1;
                        w_rd_pos = r_j + POS_W'(1);
                    end
                end else if (w_lab_bad) begin
                    n_mal = 1'b1;
                end else begin
                    n_c = i_rdata[6:0];
                    if (r_hops == '0) begin
                        n_i = r_i + POS_W'(i_rdata) + POS_W'(1);
                    end
                    w_rd_en = 1'b1;
                    w_rd_pos = r_j + POS_W'(1);
                    n_j = r_j + POS_W'(2);
                end
            end
            S_NLAB: begin
                n_ms = r_ms && w_s_ok;
                n_mh = r_mh && w_h_ok;
                n_mp = r_mp && w_p_ok;
                n_n = r_n + NW'(1);
                n_c = r_c - 7'd1;
                if (r_c != 7'd1) begin
                    w_rd_en = 1'b1;
                    w_rd_pos = r_j;
                    n_j = r_j + POS_W'(1);
                end
            end
            S_NDOT: begin
                n_ms = r_ms && w_s_ok;
                n_mh = r_mh && w_h_ok;
                n_mp = r_mp && w_p_ok;
                n_n = r_n + NW'(1);
                w_rd_en = 1'b1;
                w_rd_pos = r_j;
            end
            S_NPTR: begin
                n_j = POS_W'({r_tag[5:0], i_rdata});
                if (r_hops == HW'(1)) begin
                    n_i = r_i + POS_W'(2);
                end
                w_rd_en = 1'b1;
                w_rd_pos = POS_W'({r_tag[5:0], i_rdata});
            end
            S_AFTER: begin
                if (r_ptr) begin
                    if (!r_resp && r_is_s) begin
                        n_flags[BIT_KA_PTR] = 1'b1;
                    end
                end else begin
                    case (r_sec)
                        SEC_QUESTION: begin
                            if (r_resp) begin
                                n_i = r_i + POS_W'(4);
                            end else begin
                                w_rd_en = 1'b1;
                                w_rd_pos = r_i;
                            end
                        end
                        SEC_ANSWER: begin
                            if (r_probe && r_is_h) begin
                                n_flags[BIT_CF_HOST] = 1'b1;
                            end
                            if (r_probe && r_is_s) begin
                                n_flags[BIT_CF_SRVC] = 1'b1;
                            end
                            w_rd_en = 1'b1;
                            w_rd_pos = r_i;
                        end
                        SEC_SKIP: begin
                            w_rd_en = 1'b1;
                            w_rd_pos = r_i + POS_W'(8);
                        end
                        default: begin
                            if (r_is_h) begin
                                n_flags[BIT_AU_HOST] = 1'b1;
                            end
                            if (r_is_s) begin
                                n_flags[BIT_AU_SRVC] = 1'b1;
                            end
                            w_rd_en = 1'b1;
                            w_rd_pos = r_i + POS_W'(8);
                        end
                    endcase
                end
            end
            S_QT0: begin
                n_hi = i_rdata;
                w_rd_en = 1'b1;
                w_rd_pos = r_i + POS_W'(1);
            end
            S_QT1: begin
                n_lo = i_rdata;
                w_rd_en = 1'b1;
                w_rd_pos = r_i + POS_W'(2);
            end
            S_QC: begin
                if (({r_hi, r_lo} == TYPE_TXT) && r_is_s) begin
                    qbit = 7'd1;
                end else if (({r_hi, r_lo} == TYPE_SRV) && r_is_s) begin
                    qbit = 7'd2;
                end else if (({r_hi, r_lo} == TYPE_A) && r_is_h) begin
                    qbit = 7'd4;
                end else if (({r_hi, r_lo} == TYPE_PTR) && r_is_p) begin
                    qbit = 7'd8;
                end else if (({r_hi, r_lo} == TYPE_AAAA) && r_is_h) begin
                    qbit = 7'd16;
                end else if ({r_hi, r_lo} == TYPE_ANY) begin
                    qbit = {r_is_s, r_is_h, 5'd0};
                end
                n_flags[6:0] = r_flags[6:0] | qbit;
                if (!i_rdata[7]) begin
                    n_flags[BIT_QM +: 7] = r_flags[BIT_QM +: 7] | qbit;
                end
                n_i = r_i + POS_W'(4);
            end
            S_AT0: begin
                n_hi = i_rdata;
                w_rd_en = 1'b1;
                w_rd_pos = r_i + POS_W'(1);
            end
            S_AT1: begin
                w_rd_en = 1'b1;
                w_rd_pos = r_i + POS_W'(8);
                if ((w_typ == TYPE_TXT) && r_is_s) begin
                    n_flags[r_resp ? BIT_CF_TXT : BIT_KA_TXT] = 1'b1;
                end else if ((w_typ == TYPE_SRV) && r_is_s) begin
                    n_flags[r_resp ? BIT_CF_SRV : BIT_KA_SRV] = 1'b1;
                end else if ((w_typ == TYPE_AAAA) && r_is_h) begin
                    n_flags[r_resp ? BIT_CF_AAAA : BIT_KA_AAAA] = 1'b1;
                end else if ((w_typ == TYPE_A) && r_is_h) begin
                    n_i = r_i + POS_W'(14);
                    n_k = '0;
                    w_rd_en = r_resp;
                    w_rd_pos = r_i + POS_W'(10);
                    if (!r_resp) begin
                        n_flags[BIT_KA_A] = 1'b1;
                    end
                end else if ((w_typ == TYPE_PTR) && r_is_p) begin
                    w_rd_en = 1'b0;
                    n_i = r_i + POS_W'(10);
                    n_ptr = 1'b1;
                end
            end
            S_AA: begin
                n_addr = {r_addr[15:0], i_rdata};
                if (r_k < 4'd3) begin
                    n_k = r_k + 4'd1;
                    w_rd_en = 1'b1;
                    w_rd_pos = r_i - POS_W'(3) + POS_W'(r_k);
                end else if ({r_addr, i_rdata} != i_cfg.own_ip) begin
                    n_flags[BIT_CF_A] = 1'b1;
                end
            end
            S_SK0: begin
                n_hi = i_rdata;
                w_rd_en = 1'b1;
                w_rd_pos = r_i + POS_W'(9);
            end
            S_SK1: begin
                n_i = r_i + POS_W'(10) + POS_W'({r_hi, i_rdata});
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_res.hit_map = r_flags;
                    n_res.malformed = r_mal;
                    o_done = 1'b1;
                end
            end
            default: ;
        endcase
        // A read at or past the message end stops the walk as malformed.
        if (w_rd_en && w_rd_bad) begin
            n_mal = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_job_valid) n_state = S_START;
            S_START:  n_state = S_HDR;
            S_HDR: begin
                if ((r_k == 4'd4) && w_rej_now) begin
                    n_state = S_DONE;
                end else if (r_k == 4'd9) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                case (r_sec)
                    SEC_QUESTION:       if (r_qu != 8'd0) n_state = S_NSTART;
                    SEC_ANSWER, SEC_SKIP: if (r_an != 16'd0) n_state = S_NSTART;
                    default:            n_state = (r_au != 16'd0) ? S_NSTART : S_DONE;
                endcase
            end
            S_NSTART: n_state = S_NTAG;
            S_NTAG: begin
                if (i_rdata == 8'h00) begin
                    n_state = S_AFTER;
                end else if (w_tag_ptr) begin
                    n_state = w_hop_over ? S_DONE : S_NPTR;
                end else begin
                    n_state = w_lab_bad ? S_DONE : S_NLAB;
                end
            end
            S_NLAB:   n_state = (r_c == 7'd1) ? S_NDOT : S_NLAB;
            S_NDOT:   n_state = S_NTAG;
            S_NPTR:   n_state = S_NTAG;
            S_AFTER: begin
                if (r_ptr) begin
                    n_state = S_NEXT;
                end else begin
                    case (r_sec)
                        SEC_QUESTION: n_state = r_resp ? S_NEXT : S_QT0;
                        SEC_ANSWER:   n_state = S_AT0;
                        default:      n_state = S_SK0;
                    endcase
                end
            end
            S_QT0:    n_state = S_QT1;
            S_QT1:    n_state = S_QC;
            S_QC:     n_state = S_NEXT;
            S_AT0:    n_state = S_AT1;
            S_AT1: begin
                n_state = S_SK0;
                if (!((w_typ == TYPE_TXT) && r_is_s) && !((w_typ == TYPE_SRV) && r_is_s)
                    && !((w_typ == TYPE_AAAA) && r_is_h)) begin
                    if ((w_typ == TYPE_A) && r_is_h) begin
                        n_state = r_resp ? S_AA : S_NEXT;
                    end else if ((w_typ == TYPE_PTR) && r_is_p) begin
                        n_state = S_NSTART;
                    end
                end
            end
            S_AA:     n_state = (r_k < 4'd3) ? S_AA : S_NEXT;
            S_SK0:    n_state = S_SK1;
            S_SK1:    n_state = S_NEXT;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (w_rd_en && w_rd_bad) begin
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec <= n_sec; r_ptr <= n_ptr; r_len <= n_len; r_probe <= n_probe;
        r_resp <= n_resp; r_rej <= n_rej; r_k <= n_k; r_qu <= n_qu;
        r_an <= n_an; r_au <= n_au; r_i <= n_i; r_j <= n_j; r_n <= n_n;
        r_hops <= n_hops; r_c <= n_c; r_tag <= n_tag; r_hi <= n_hi; r_lo <= n_lo;
        r_addr <= n_addr; r_ms <= n_ms; r_mh <= n_mh; r_mp <= n_mp;
        r_is_s <= n_is_s; r_is_h <= n_is_h; r_is_p <= n_is_p;
        r_flags <= n_flags; r_mal <= n_mal; r_res <= n_res;
    end

    logic w_unused;
    assign w_unused = ^w_ptr;
endmodule

// ----- sv/mdns_packet_classifier.sv -----
// Top level of the mDNS packet classifier: configuration registers and the front and back ends.
// Operation: each byte is stored as it is taken; after the last byte the walk reads the stored
// message, at most one byte per cycle, then the result registers.
// Throughput: one byte per cycle while loading and the input is ready; the next message loads once
// the result of the previous one sits in the output register, since both share the one packet store.
// Reset: synchronous, active low; clears configuration, byte count, job queue and result valid.
`timescale 1ns / 1ps
module mdns_packet_classifier
    import mpc_pkg::*;
#(
    parameter int PACKET_BYTES = 2048,
    parameter int NAME_LIMIT = 93,
    parameter int HOST_LABEL_BYTES = 24,
    parameter int POINTER_HOP_LIMIT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpc_in_if.sink      i_in,
    mpc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    localparam int LW = $clog2(PACKET_BYTES + 1);
    localparam int AW = $clog2(PACKET_BYTES);

    t_cfg          r_cfg;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    logic          w_push;
    logic [LW:0]   w_job_in;
    logic [LW:0]   w_job_out;
    logic          w_q_full;
    logic          w_q_valid;
    logic          w_pop;
    logic          w_done;
    t_result       w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEV_LOW:  r_cfg.dev_low <= i_cfg_data;
                CFG_DEV_MID:  r_cfg.dev_mid <= i_cfg_data;
                CFG_DEV_LAST: r_cfg.dev_last <= i_cfg_data[7:0];
                CFG_HOST_A:   r_cfg.host_a <= i_cfg_data;
                CFG_HOST_B:   r_cfg.host_b <= i_cfg_data;
                CFG_HOST_C:   r_cfg.host_c <= i_cfg_data;
                CFG_HOST_LEN: r_cfg.host_len <= i_cfg_data[4:0];
                CFG_OWN_IP:   r_cfg.own_ip <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    mpc_loader #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_loader (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_push   (w_push),
        .o_job    (w_job_in),
        .i_q_full (w_q_full),
        .i_done   (w_done)
    );

    mpc_ram #(
        .WIDTH(8),
        .DEPTH(PACKET_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mpc_job_queue #(
        .DW(LW + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_job_out)
    );

    mpc_parser #(
        .PACKET_BYTES(PACKET_BYTES),
        .NAME_LIMIT(NAME_LIMIT),
        .HOST_LABEL_BYTES(HOST_LABEL_BYTES),
        .POINTER_HOP_LIMIT(POINTER_HOP_LIMIT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_q_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_pop),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_done      (w_done),
        .o_res_valid (o_out.valid),
        .i_res_ready (o_out.ready),
        .o_res       (w_res)
    );

    assign o_out.hit_map = w_res.hit_map;
    assign o_out.malformed = w_res.malformed;
endmodule

// ----- dv/mpc_checker.sv -----
// Checker for the mDNS packet classifier: predicts each message result and compares it.
`timescale 1ns / 1ps
module mpc_checker
    import mpc_pkg::*;
#(
    parameter int PACKET_BYTES = 2048,
    parameter int NAME_LIMIT = 93,
    parameter int HOST_LABEL_BYTES = 24,
    parameter int POINTER_HOP_LIMIT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpc_in_if           in_ch,
    mpc_out_if          out_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef enum int {NM_SRVC, NM_HOST, NM_HAP} t_target;

    t_cfg        cfg;
    logic [7:0]  msg_bytes [PACKET_BYTES];
    int unsigned stored;
    int unsigned msg_len;
    bit          walk_bad;
    logic [7:0]  name_buf [NAME_LIMIT + 3];
    int unsigned name_n;
    logic [7:0]  srvc_name [SRVC_LEN];
    logic [7:0]  host_name [REG_LABEL_BYTES + 7];
    int unsigned host_n;
    logic [31:0] hits;
    t_result     expected_q [$];

    function automatic int unsigned fetch(int unsigned pos);
        if (pos >= msg_len) begin
            walk_bad = 1'b1;
            return 0;
        end
        return msg_bytes[pos];
    endfunction

    // Expands one possibly compressed name into name_buf and advances ip past it.
    function automatic bit read_name(inout int unsigned ip);
        int unsigned i, j, n, hops, tag, lo;
        i = ip;
        j = ip;
        n = 0;
        hops = 0;
        tag = fetch(j);
        if (walk_bad) return 0;
        while (tag != 0) begin
            if (tag >= TAG_PTR) begin
                hops++;
                if (hops > POINTER_HOP_LIMIT) begin
                    walk_bad = 1'b1;
                    return 0;
                end
                lo = fetch(j + 1);
                if (walk_bad) return 0;
                j = ((tag - TAG_PTR) << 8) | lo;
                if (hops == 1) i += 2;
            end else begin
                if (tag > TAG_MAX_LABEL || j + 1 + tag > msg_len || n + tag > NAME_LIMIT) begin
                    walk_bad = 1'b1;
                    return 0;
                end
                for (int k = 0; k < tag; k++) name_buf[n + k] = msg_bytes[j + 1 + k];
                n += tag;
                name_buf[n] = CHAR_DOT;
                n++;
                j += tag + 1;
                if (hops == 0) i += tag + 1;
            end
            tag = fetch(j);
            if (walk_bad) return 0;
        end
        if (hops == 0) i++;
        name_n = n;
        ip = i;
        return 1;
    endfunction

    function automatic bit name_eq(t_target w);
        case (w)
            NM_SRVC: begin
                if (name_n != SRVC_LEN) return 0;
                for (int k = 0; k < SRVC_LEN; k++) if (name_buf[k] != srvc_name[k]) return 0;
            end
            NM_HOST: begin
                if (name_n != host_n) return 0;
                for (int k = 0; k < host_n; k++) if (name_buf[k] != host_name[k]) return 0;
            end
            default: begin
                if (name_n != HAP_LEN) return 0;
                for (int k = 0; k < HAP_LEN; k++) if (name_buf[k] != HAP_NAME[k]) return 0;
            end
        endcase
        return 1;
    endfunction

    function automatic bit skip_rdata(inout int unsigned ip);
        int unsigned i, hi, lo;
        i = ip + 8;
        hi = fetch(i);
        lo = fetch(i + 1);
        if (walk_bad) return 0;
        ip = i + 2 + (hi << 8) + lo;
        return 1;
    endfunction

    // Walks the stored message; hits collects the flags, the return value is malformed.
    function automatic bit classify(bit probing);
        int unsigned hd [10];
        int unsigned i, qu, an, au, typ, lim, a;
        logic [7:0] qbits;
        bit resp, qm, walk;
        hits = '0;
        walk_bad = 1'b0;
        for (int k = 0; k < ID_BYTES; k++)
            srvc_name[k] = k < 8 ? cfg.dev_low[8*k +: 8] :
                           k < 16 ? cfg.dev_mid[8*(k-8) +: 8] : cfg.dev_last;
        srvc_name[ID_BYTES] = CHAR_DOT;
        for (int k = 0; k < HAP_LEN; k++) srvc_name[ID_BYTES + 1 + k] = HAP_NAME[k];
        lim = cfg.host_len;
        if (lim > REG_LABEL_BYTES) lim = REG_LABEL_BYTES;
        if (lim > HOST_LABEL_BYTES) lim = HOST_LABEL_BYTES;
        for (int k = 0; k < lim; k++)
            host_name[k] = k < 8 ? cfg.host_a[8*k +: 8] :
                           k < 16 ? cfg.host_b[8*(k-8) +: 8] : cfg.host_c[8*(k-16) +: 8];
        for (int k = 0; k < 7; k++) host_name[lim + k] = HAP_NAME[HOST_SUFFIX_AT + k];
        host_n = lim + 7;

        for (int k = 0; k < 5; k++) hd[k] = fetch(k);
        if (walk_bad) return 1;
        if (hd[0] != 0 || hd[1] != 0 || hd[3] != 0 || hd[4] != 0) return 0;
        if (hd[2] != 0 && hd[2] != FLAGS_RESPONSE) return 0;
        resp = hd[2] == FLAGS_RESPONSE;
        for (int k = 5; k < 10; k++) hd[k] = fetch(k);
        if (walk_bad) return 1;
        qu = hd[5];
        an = (hd[6] << 8) | hd[7];
        au = (hd[8] << 8) | hd[9];
        i = 12;

        for (; qu != 0; qu--) begin
            if (!read_name(i)) return 1;
            if (!resp) begin
                typ = (fetch(i) << 8) | fetch(i + 1);
                qm = (fetch(i + 2) & 8'h80) == 0;
                if (walk_bad) return 1;
                qbits = '0;
                if (typ == TYPE_TXT && name_eq(NM_SRVC)) qbits = 8'd1;
                else if (typ == TYPE_SRV && name_eq(NM_SRVC)) qbits = 8'd2;
                else if (typ == TYPE_A && name_eq(NM_HOST)) qbits = 8'd4;
                else if (typ == TYPE_PTR && name_eq(NM_HAP)) qbits = 8'd8;
                else if (typ == TYPE_AAAA && name_eq(NM_HOST)) qbits = 8'd16;
                else if (typ == TYPE_ANY) begin
                    if (name_eq(NM_HOST)) qbits[5] = 1'b1;
                    if (name_eq(NM_SRVC)) qbits[6] = 1'b1;
                end
                hits[7:0] |= qbits;
                if (qm) hits[BIT_QM +: 8] |= qbits;
            end
            i += 4;
        end

        if (hits != 0 || resp) begin
            for (; an != 0; an--) begin
                walk = 1'b1;
                if (!read_name(i)) return 1;
                if (probing && name_eq(NM_HOST)) hits[BIT_CF_HOST] = 1'b1;
                if (probing && name_eq(NM_SRVC)) hits[BIT_CF_SRVC] = 1'b1;
                typ = (fetch(i) << 8) | fetch(i + 1);
                if (walk_bad) return 1;
                if (typ == TYPE_TXT && name_eq(NM_SRVC))
                    hits[resp ? BIT_CF_TXT : BIT_KA_TXT] = 1'b1;
                else if (typ == TYPE_SRV && name_eq(NM_SRVC))
                    hits[resp ? BIT_CF_SRV : BIT_KA_SRV] = 1'b1;
                else if (typ == TYPE_AAAA && name_eq(NM_HOST))
                    hits[resp ? BIT_CF_AAAA : BIT_KA_AAAA] = 1'b1;
                else if (typ == TYPE_A && name_eq(NM_HOST)) begin
                    walk = 1'b0;
                    i += 14;
                    if (resp) begin
                        a = (fetch(i - 4) << 24) | (fetch(i - 3) << 16) |
                            (fetch(i - 2) << 8) | fetch(i - 1);
                        if (walk_bad) return 1;
                        if (a != cfg.own_ip) hits[BIT_CF_A] = 1'b1;
                    end else begin
                        hits[BIT_KA_A] = 1'b1;
                    end
                end else if (typ == TYPE_PTR && name_eq(NM_HAP)) begin
                    walk = 1'b0;
                    i += 10;
                    if (!read_name(i)) return 1;
                    if (!resp && name_eq(NM_SRVC)) hits[BIT_KA_PTR] = 1'b1;
                end
                if (walk && !skip_rdata(i)) return 1;
            end
        end else begin
            for (; an != 0; an--) begin
                if (!read_name(i)) return 1;
                if (!skip_rdata(i)) return 1;
            end
        end

        for (; au != 0; au--) begin
            if (!read_name(i)) return 1;
            if (name_eq(NM_HOST)) hits[BIT_AU_HOST] = 1'b1;
            if (name_eq(NM_SRVC)) hits[BIT_AU_SRVC] = 1'b1;
            if (!skip_rdata(i)) return 1;
        end
        return 0;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            cfg = '0;
            stored = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEV_LOW:  cfg.dev_low = i_cfg_data;
                    CFG_DEV_MID:  cfg.dev_mid = i_cfg_data;
                    CFG_DEV_LAST: cfg.dev_last = i_cfg_data[7:0];
                    CFG_HOST_A:   cfg.host_a = i_cfg_data;
                    CFG_HOST_B:   cfg.host_b = i_cfg_data;
                    CFG_HOST_C:   cfg.host_c = i_cfg_data;
                    CFG_HOST_LEN: cfg.host_len = i_cfg_data[4:0];
                    CFG_OWN_IP:   cfg.own_ip = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.hit_map = out_ch.hit_map;
                got.malformed = out_ch.malformed;
                if (expected_q.size() == 0) begin
                    $error("result with no message pending: hit_map %h malformed %0d",
                           got.hit_map, got.malformed);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.hit_map !== want.hit_map) begin
                        $error("hit_map expected %h actual %h", want.hit_map, got.hit_map);
                        o_errors++;
                    end
                    if (got.malformed !== want.malformed) begin
                        $error("malformed expected %0d actual %0d", want.malformed,
                               got.malformed);
                        o_errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                // Bytes beyond the store are dropped; the message is the stored prefix.
                if (stored < PACKET_BYTES) begin
                    msg_bytes[stored] = in_ch.packet_byte;
                    stored++;
                end
                if (in_ch.last_byte) begin
                    msg_len = stored;
                    want.malformed = classify(in_ch.probing_now);
                    want.hit_map = hits[30:0];
                    expected_q.push_back(want);
                    stored = 0;
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- dv/tb_mdns_packet_classifier.sv -----
// Testbench top of the mDNS packet classifier: builds messages, drives them and gives the verdict.
`timescale 1ns / 1ps
module tb_mdns_packet_classifier;
    import mpc_pkg::*;

    typedef enum int {K_SRVC, K_HOST, K_HAP, K_OTHER} t_name_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_data;
    int          errors;
    int          pending;
    bit          calm;
    int          stall_left;
    int          sent_bytes;
    int          sent_msgs;
    t_cfg        cur;
    logic [7:0]  msg [$];
    int          hap_at;
    int          local_at;

    mpc_in_if  in_ch ();
    mpc_out_if out_ch ();

    mdns_packet_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mpc_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("FAIL mdns_packet_classifier");
        $finish;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = gap_len();
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] d);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
    endtask

    task automatic apply_cfg(int phase);
        logic [63:0] raw [8];
        bit ascii;
        ascii = $urandom_range(0, 2) != 0;
        for (int r = 0; r < 8; r++) begin
            raw[r] = {$urandom, $urandom};
            if (ascii)
                for (int k = 0; k < 8; k++) raw[r][8*k +: 8] = 8'($urandom_range(8'h2D, 8'h7A));
        end
        raw[CFG_HOST_LEN][4:0] = 5'($urandom_range(0, 31));
        if (phase == 0) foreach (raw[r]) raw[r] = '0;
        if (phase == 1) foreach (raw[r]) raw[r] = '1;
        if (phase == 2) raw[CFG_HOST_LEN][4:0] = 5'd0;
        if (phase == 3) raw[CFG_HOST_LEN][4:0] = 5'd24;
        for (int r = 0; r < 8; r++) write_reg(t_cfg_idx'(r), raw[r]);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur.dev_low = raw[CFG_DEV_LOW];
        cur.dev_mid = raw[CFG_DEV_MID];
        cur.dev_last = raw[CFG_DEV_LAST][7:0];
        cur.host_a = raw[CFG_HOST_A];
        cur.host_b = raw[CFG_HOST_B];
        cur.host_c = raw[CFG_HOST_C];
        cur.host_len = raw[CFG_HOST_LEN][4:0];
        cur.own_ip = raw[CFG_OWN_IP][31:0];
    endtask

    task automatic send_byte(logic [7:0] b, bit last, bit probe);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            in_ch.packet_byte <= 8'($urandom);
            in_ch.last_byte <= 1'($urandom);
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.packet_byte <= b;
        in_ch.last_byte <= last;
        in_ch.probing_now <= probe;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message();
        bit probe;
        probe = 1'($urandom);
        foreach (msg[k])
            send_byte(msg[k], k == msg.size() - 1, k == msg.size() - 1 ? probe : 1'($urandom));
        sent_bytes += msg.size();
        sent_msgs++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic void push_word(int w);
        msg.push_back(8'(w >> 8));
        msg.push_back(8'(w));
    endfunction

    function automatic void push_label(string s);
        msg.push_back(8'(s.len()));
        for (int k = 0; k < s.len(); k++) msg.push_back(s[k]);
    endfunction

    function automatic void push_pointer(int at);
        msg.push_back(TAG_PTR | 8'(at >> 8));
        msg.push_back(8'(at));
    endfunction

    function automatic void header(logic [7:0] flags, int qd, int an, int au);
        msg.delete();
        hap_at = -1;
        local_at = -1;
        msg.push_back(8'h00);
        msg.push_back(8'h00);
        msg.push_back(flags);
        msg.push_back(8'h00);
        push_word(qd);
        push_word(an);
        push_word(au);
        push_word(0);
    endfunction

    // Ends the name with "local." either written out or as a back pointer.
    function automatic void add_local();
        if (local_at >= 0 && $urandom_range(0, 1)) begin
            push_pointer(local_at);
        end else begin
            local_at = msg.size();
            push_label("local");
            msg.push_back(8'h00);
        end
    endfunction

    function automatic void add_hap();
        if (hap_at >= 0 && $urandom_range(0, 1)) begin
            push_pointer(hap_at);
        end else begin
            hap_at = msg.size();
            push_label("_hap");
            push_label("_tcp");
            add_local();
        end
    endfunction

    function automatic void add_name(t_name_kind kind);
        int start, lim;
        start = msg.size();
        case (kind)
            K_SRVC: begin
                msg.push_back(8'(ID_BYTES));
                for (int k = 0; k < ID_BYTES; k++)
                    msg.push_back(k < 8 ? cur.dev_low[8*k +: 8] :
                                  k < 16 ? cur.dev_mid[8*(k-8) +: 8] : cur.dev_last);
                add_hap();
            end
            K_HOST: begin
                lim = cur.host_len > REG_LABEL_BYTES ? REG_LABEL_BYTES : cur.host_len;
                if (lim > 0) begin
                    msg.push_back(8'(lim));
                    for (int k = 0; k < lim; k++)
                        msg.push_back(k < 8 ? cur.host_a[8*k +: 8] :
                                      k < 16 ? cur.host_b[8*(k-8) +: 8] :
                                      cur.host_c[8*(k-16) +: 8]);
                end
                add_local();
            end
            K_HAP: add_hap();
            default: begin
                msg.push_back(8'($urandom_range(1, 8)));
                for (int k = msg[msg.size() - 1]; k > 0; k--) msg.push_back(8'($urandom));
                case ($urandom_range(0, 2))
                    0: add_hap();
                    1: add_local();
                    default: msg.push_back(8'h00);
                endcase
            end
        endcase
        // A near miss: one bit of the name is off.
        if ($urandom_range(0, 11) == 0)
            msg[$urandom_range(start, msg.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    endfunction

    function automatic int pick_type(t_name_kind kind);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return $urandom_range(0, 65535);
        case (kind)
            K_SRVC: return r % 3 == 0 ? TYPE_TXT : r % 3 == 1 ? TYPE_SRV : TYPE_ANY;
            K_HOST: return r % 3 == 0 ? TYPE_A : r % 3 == 1 ? TYPE_AAAA : TYPE_ANY;
            K_HAP: return TYPE_PTR;
            default: return r % 2 ? TYPE_ANY : TYPE_TXT;
        endcase
    endfunction

    function automatic void build_message();
        int qd, an, au, typ, start, n;
        bit resp;
        t_name_kind kind;
        resp = $urandom_range(0, 2) == 0;
        qd = $urandom_range(0, 3);
        an = $urandom_range(0, 2);
        au = $urandom_range(0, 3) == 0;
        header(resp ? FLAGS_RESPONSE : 8'h00, qd, an, au);
        for (int q = 0; q < qd; q++) begin
            kind = t_name_kind'($urandom_range(0, 3));
            add_name(kind);
            push_word(pick_type(kind));
            msg.push_back(8'($urandom_range(0, 1) << 7));
            msg.push_back(8'h01);
        end
        for (int a = 0; a < an; a++) begin
            kind = t_name_kind'($urandom_range(0, 3));
            add_name(kind);
            typ = pick_type(kind);
            push_word(typ);
            push_word($urandom_range(0, 65535));
            push_word($urandom_range(0, 65535));
            push_word($urandom_range(0, 65535));
            if (typ == TYPE_A && kind == K_HOST) begin
                push_word(4);
                push_word($urandom_range(0, 1) ? cur.own_ip[31:16] : $urandom_range(0, 65535));
                push_word($urandom_range(0, 3) ? cur.own_ip[15:0] : $urandom_range(0, 65535));
            end else if (typ == TYPE_PTR && kind == K_HAP) begin
                start = msg.size();
                push_word(0);
                add_name($urandom_range(0, 2) ? K_SRVC : K_OTHER);
                n = msg.size() - start - 2;
                msg[start] = 8'(n >> 8);
                msg[start + 1] = 8'(n);
            end else begin
                n = $urandom_range(0, 4);
                push_word(n);
                repeat (n) msg.push_back(8'($urandom));
            end
        end
        for (int u = 0; u < au; u++) begin
            add_name(t_name_kind'($urandom_range(0, 3)));
            repeat (8) msg.push_back(8'($urandom));
            n = $urandom_range(0, 3);
            push_word(n);
            repeat (n) msg.push_back(8'($urandom));
        end
    endfunction

    task automatic directed_messages();
        msg = '{8'h00};
        send_message();
        header(8'h00, 1, 0, 0);
        msg[0] = 8'h01;
        send_message();
        header(8'h85, 1, 0, 0);
        send_message();
        header(8'h00, 1, 0, 0);
        msg[3] = 8'h01;
        send_message();
        header(8'h00, 256, 0, 0);
        send_message();
        // A name that points at itself.
        header(8'h00, 1, 0, 0);
        push_pointer(12);
        send_message();
        header(8'h00, 1, 0, 0);
        msg.push_back(8'h41);
        repeat (6) msg.push_back(8'h61);
        send_message();
        // Label longer than what is left of the message.
        header(8'h84, 0, 1, 0);
        msg.push_back(8'h0A);
        repeat (3) msg.push_back(8'h62);
        send_message();
        // Two full-size labels exceed the name limit.
        header(8'h00, 1, 0, 0);
        repeat (2) begin
            msg.push_back(TAG_MAX_LABEL);
            repeat (64) msg.push_back(8'h63);
        end
        msg.push_back(8'h00);
        push_word(TYPE_ANY);
        push_word(1);
        send_message();
        msg.delete();
        repeat (20) msg.push_back(8'hFF);
        send_message();
        header(8'h84, 0, 16'hFFFF, 0);
        send_message();
        // More bytes than the store holds; only the prefix counts.
        build_message();
        while (msg.size() < 2100) msg.push_back(8'($urandom));
        send_message();
    endtask

    initial begin
        int phase;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.packet_byte = '0;
        in_ch.last_byte = 1'b0;
        in_ch.probing_now = 1'b0;
        calm = 1'b0;
        sent_bytes = 0;
        sent_msgs = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        apply_cfg(0);
        directed_messages();
        drain();
        phase = 1;
        while (sent_bytes < 1300 || sent_msgs < 70) begin
            apply_cfg(phase);
            calm = phase % 4 == 3;
            repeat (8) begin
                if ($urandom_range(0, 9) == 0) begin
                    msg.delete();
                    repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom));
                end else begin
                    build_message();
                    if ($urandom_range(0, 7) == 0)
                        msg = msg[0:$urandom_range(0, msg.size() - 1)];
                    if ($urandom_range(0, 9) == 0)
                        msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
                end
                send_message();
            end
            drain();
            phase++;
        end
        calm = 1'b0;
        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS mdns_packet_classifier");
        end else begin
            $display("FAIL mdns_packet_classifier");
        end
        $finish;
    end

endmodule
